@@ hdl/aes128kx_pkg.sv @@
// Shared types, constants and tables for the AES-128 key expander.
package aes128kx_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned NUM_W       = 6;
    localparam int unsigned SCHED_WORDS = 44;

    localparam logic [NUM_W-1:0] LAST_NUM  = NUM_W'(SCHED_WORDS - 1);
    localparam logic [NUM_W-1:0] FIRST_GEN = NUM_W'(4);
    localparam logic [1:0]       START_IDX = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX[b];
    endfunction

    // Round constant for round 1..10; other codes give zero.
    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/aes128kx_sub_word.sv @@
// Key schedule core function: rotate word, S-box each byte, add round constant.
module aes128kx_sub_word
(
    input  aes128kx_pkg::word_t word_in,
    input  logic [3:0]          round,
    output aes128kx_pkg::word_t word_out
);
    import aes128kx_pkg::*;

    word_t rot;

    // byte 1 moves to byte 0, byte 0 to byte 3
    assign rot = {word_in[7:0], word_in[31:8]};

    assign word_out = {sbox(rot[31:24]),
                       sbox(rot[23:16]),
                       sbox(rot[15:8]),
                       sbox(rot[7:0]) ^ rcon(round)};

endmodule

@@ hdl/aes128_key_expander.sv @@
// AES-128 key expander top level: key word load and schedule sequencer.
//
// Input channel (in_valid / in_stall): one transfer carries key_word and its
// slot word_index. Slots 0..2 are only stored. A transfer with index 3 stores
// the word and starts the expansion of the whole stored key.
// Output channel (out_valid / out_stall): 44 transfers, round_key_word with
// its word_number 0..43; last_word marks word 43.
// Timing: after the index-3 transfer has loaded the working window, word 0
// is loaded into the output register and one word follows per cycle while
// the receiver takes them. One shared sub-word unit and a four word sliding
// window produce one schedule word per cycle while the output register is
// free.
// in_stall is high from the start of an expansion until word 43 has been
// loaded into the output register; the next key words may be taken while
// word 43 still waits there.
// When out_stall is high the output register holds its word and the
// sequencer pauses; nothing is dropped.
// Reset clears the stored key slots to zero and returns to idle.
module aes128_key_expander
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [31:0]           key_word,
    input  logic [1:0]            word_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           round_key_word,
    output logic [5:0]            word_number,
    output logic                  last_word
);
    import aes128kx_pkg::*;

    state_t           state_reg, state_next;
    word_t            key_reg  [4];
    word_t            work_reg [4];
    logic [NUM_W-1:0] count_reg;
    logic             out_valid_reg, out_valid_next;
    word_t            out_word_reg;
    logic [NUM_W-1:0] out_num_reg;
    logic             out_last_reg;

    logic             in_xfer;
    logic             start;
    logic             step;
    logic             slot_free;
    logic             gen_word;
    word_t            sub_out;
    word_t            temp;
    word_t            new_word;
    word_t            emit_word;

    assign in_xfer   = in_valid && !in_stall;
    assign start     = in_xfer && (word_index == START_IDX);
    assign slot_free = !out_valid_reg || !out_stall;

    aes128kx_sub_word u_sub_word
    (
        .word_in  (work_reg[3]),
        .round    (count_reg[5:2]),
        .word_out (sub_out)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (slot_free && count_reg == LAST_NUM)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall = 1'b0;
        step     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                step     = 1'b0;
            end
            ST_RUN:
            begin
                in_stall = 1'b1;
                step     = slot_free;
            end
            default:
            begin
                in_stall = 1'b1;
                step     = 1'b0;
            end
        endcase
    end

    // words 0..3 come straight from the window, later ones are generated
    assign gen_word  = (count_reg >= FIRST_GEN);
    assign temp      = (count_reg[1:0] == 2'd0) ? sub_out : work_reg[3];
    assign new_word  = work_reg[0] ^ temp;
    assign emit_word = gen_word ? new_word : work_reg[count_reg[1:0]];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (in_xfer)
            begin
                key_reg[word_index] <= key_word;
            end
            if (start)
            begin
                count_reg <= '0;
            end
            else if (step)
            begin
                count_reg <= count_reg + NUM_W'(1);
            end
        end
    end

    // working window and output data
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 4; i++)
            begin
                work_reg[i] <= (word_index == 2'(i)) ? key_word : key_reg[i];
            end
        end
        else if (step && gen_word)
        begin
            work_reg[0] <= work_reg[1];
            work_reg[1] <= work_reg[2];
            work_reg[2] <= work_reg[3];
            work_reg[3] <= new_word;
        end
        if (step)
        begin
            out_word_reg <= emit_word;
            out_num_reg  <= count_reg;
            out_last_reg <= (count_reg == LAST_NUM);
        end
    end

    assign out_valid      = out_valid_reg;
    assign round_key_word = out_word_reg;
    assign word_number    = out_num_reg;
    assign last_word      = out_last_reg;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the AES-128 key expander: key loads against a predicted schedule.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aes128kx_pkg::*;

    localparam logic [1:0] SLOT_0     = 2'd0;
    localparam logic [1:0] SLOT_1     = 2'd1;
    localparam logic [1:0] SLOT_2     = 2'd2;
    localparam int         LONG_HOLD  = 300;
    localparam int         TAIL_WAIT  = 60;
    localparam int         WORD_GOAL  = 120;
    localparam int         PRINT_CAP  = 50;

    typedef struct packed
    {
        word_t            word;
        logic [NUM_W-1:0] num;
        logic             last;
    } sched_entry_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [31:0]      key_word;
    logic [1:0]       word_index;
    logic             out_valid;
    logic             out_stall;
    logic [31:0]      round_key_word;
    logic [5:0]       word_number;
    logic             last_word;

    // predictor state: the four stored key slots
    word_t            key_slots [4];
    sched_entry_t     pending_words [$];

    int               mismatch_count;
    int               words_sent;
    int               schedules_started;
    int               words_checked;
    bit               gaps_on;
    logic             stall_on;
    logic             long_hold;
    event             hold_go;

    aes128_key_expander u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .key_word       (key_word),
        .word_index     (word_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .round_key_word (round_key_word),
        .word_number    (word_number),
        .last_word      (last_word)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d schedule words still outstanding", pending_words.size());
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("MISMATCH @%0t: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    // RotWord then SubWord; byte 0 is the first key byte
    function automatic word_t rot_sub_word(input word_t w);
        word_t r;
        r = {w[7:0], w[31:8]};
        for (int b = 0; b < 4; b++)
        begin
            r[8*b +: 8] = SBOX[r[8*b +: 8]];
        end
        return r;
    endfunction

    task automatic queue_schedule();
        word_t        w [SCHED_WORDS];
        word_t        t;
        logic [7:0]   rc;
        sched_entry_t entry;
        rc = 8'h01;
        for (int i = 0; i < 4; i++)
        begin
            w[i] = key_slots[i];
        end
        for (int i = 4; i < SCHED_WORDS; i++)
        begin
            t = w[i-1];
            if (i % 4 == 0)
            begin
                t  = rot_sub_word(t) ^ {24'h0, rc};
                // GF(2^8) doubling gives the next round constant
                rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int i = 0; i < SCHED_WORDS; i++)
        begin
            entry.word = w[i];
            entry.num  = NUM_W'(i);
            entry.last = (entry.num == LAST_NUM);
            pending_words.push_back(entry);
        end
        schedules_started++;
    endtask

    // One input transfer; the predictor is updated at the accepting edge.
    task automatic send_key_word(input word_t w, input logic [1:0] idx);
        while (gaps_on && $urandom_range(0, 99) < 37)
        begin
            in_valid   <= 1'b0;
            key_word   <= $urandom;
            word_index <= 2'($urandom_range(0, 3));
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        key_word   <= w;
        word_index <= idx;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        key_slots[idx] = w;
        words_sent++;
        if (idx == START_IDX)
        begin
            queue_schedule();
        end
    endtask

    function automatic word_t pick_key_word();
        word_t w;
        case ($urandom_range(0, 7))
            0:       w = '0;
            1:       w = '1;
            2:       w = {4{8'($urandom_range(0, 255))}};
            3:       w = 32'h80808080 >> $urandom_range(0, 7);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Slots 0..2 in shuffled order, then the start slot.
    task automatic send_whole_key();
        logic [1:0] order [3];
        logic [1:0] tmp;
        int         j;
        order[0] = SLOT_0;
        order[1] = SLOT_1;
        order[2] = SLOT_2;
        for (int i = 2; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < 3; i++)
        begin
            send_key_word(pick_key_word(), order[i]);
        end
        send_key_word(pick_key_word(), START_IDX);
    endtask

    task automatic wait_schedules_drained();
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        // start with every slot still at reset zero but the start slot
        send_key_word(32'h01234567, START_IDX);
        // FIPS-197 appendix key, first byte in the low bits
        send_key_word(32'h16157e2b, SLOT_0);
        send_key_word(32'ha6d2ae28, SLOT_1);
        send_key_word(32'h8815f7ab, SLOT_2);
        send_key_word(32'h3c4fcf09, START_IDX);
        // same key again, start slot rewritten with its own value
        send_key_word(32'h3c4fcf09, START_IDX);
        // all ones
        send_key_word('1, SLOT_0);
        send_key_word('1, SLOT_1);
        send_key_word('1, SLOT_2);
        send_key_word('1, START_IDX);
        // rewrite slot 1 twice, reverse order, then start
        send_key_word(32'h0000_ff00, SLOT_2);
        send_key_word(32'hdead_beef, SLOT_1);
        send_key_word(32'h00ff_0000, SLOT_1);
        send_key_word(32'hff00_0000, SLOT_0);
        send_key_word(32'h0000_00ff, START_IDX);
        // all zero
        send_key_word('0, SLOT_0);
        send_key_word('0, SLOT_1);
        send_key_word('0, SLOT_2);
        send_key_word('0, START_IDX);
    endtask

    task automatic test_back_to_back();
        gaps_on  = 1'b0;
        stall_on <= 1'b0;
        repeat (4)
        begin
            send_whole_key();
        end
        gaps_on  = 1'b1;
        stall_on <= 1'b1;
    endtask

    task automatic test_output_backpressure();
        // receiver holds off while the sender keeps offering whole keys
        -> hold_go;
        repeat (3)
        begin
            send_whole_key();
        end
        in_valid <= 1'b0;
        wait_schedules_drained();
    endtask

    task automatic test_random_keys();
        int pick;
        while (words_sent < WORD_GOAL)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                send_whole_key();
            end
            else if (pick < 9)
            begin
                // broken sequence: a few slot writes and no start
                repeat ($urandom_range(1, 3))
                begin
                    send_key_word(pick_key_word(), 2'($urandom_range(0, 2)));
                end
            end
            else
            begin
                send_key_word(pick_key_word(), 2'($urandom_range(0, 3)));
            end
        end
    endtask

    // out_stall: random stalls, or a long hold-off counted here
    initial
    begin
        long_hold = 1'b0;
        forever
        begin
            @(hold_go);
            long_hold <= 1'b1;
            repeat (LONG_HOLD)
            begin
                @(posedge clk);
            end
            long_hold <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= long_hold || (stall_on && $urandom_range(0, 99) < 37);
    end

    always @(posedge clk)
    begin : check_output
        sched_entry_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_checked++;
            if (pending_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %0d = %h",
                                          word_number, round_key_word));
            end
            else
            begin
                want = pending_words.pop_front();
                if (round_key_word !== want.word)
                begin
                    report_mismatch($sformatf("word %0d: got %h, want %h",
                                              want.num, round_key_word, want.word));
                end
                if (word_number !== want.num)
                begin
                    report_mismatch($sformatf("word_number: got %0d, want %0d",
                                              word_number, want.num));
                end
                if (last_word !== want.last)
                begin
                    report_mismatch($sformatf("last_word on word %0d: got %b, want %b",
                                              want.num, last_word, want.last));
                end
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        key_word   = '0;
        word_index = '0;
        out_stall  = 1'b0;
        stall_on   = 1'b1;
        gaps_on    = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            key_slots[i] = '0;
        end
        repeat (9)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_back_to_back();
        test_output_backpressure();
        test_random_keys();

        in_valid <= 1'b0;
        wait_schedules_drained();
        repeat (TAIL_WAIT)
        begin
            @(posedge clk);
        end

        $display("covered: %0d key word transfers, %0d full schedules, %0d schedule words checked",
                 words_sent, schedules_started, words_checked);
        $display("incl. unwritten slots, slot rewrites, back-to-back keys and a long output hold-off");
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ aes128_key_expander.f @@
hdl/aes128kx_pkg.sv
hdl/aes128kx_sub_word.sv
hdl/aes128_key_expander.sv
verif/tb.sv
